// File: src/sgas_pkg.sv
`default_nettype none

package sgas_pkg;

   localparam int SCORE_W = 23;
   localparam int LEN_W   = 17;
   localparam int COL_W   = 16;
   localparam int SYM_W   = 2;
   localparam int GAP_W   = 16;
   localparam int SUB_W   = 16;
   localparam int NUM_SYM = 4;
   localparam int REG_W   = 64;
   localparam int CSR_IDX_W = 3;

   typedef logic signed [SCORE_W-1:0] score_type;
   typedef logic [LEN_W-1:0]          len_type;
   typedef logic signed [GAP_W-1:0]   gap_type;
   typedef logic [NUM_SYM-1:0][REG_W-1:0] sub_table_type;

   localparam len_type LEN_MAX = {LEN_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] REG_GAP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SUB_A = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SUB_C = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SUB_G = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SUB_T = 3'd4;

   // request travelling down the row of cells
   typedef struct packed {
      logic                is_ref;
      logic                scored;
      logic                first;
      logic                last;
      logic                over;
      logic                wr;
      logic [SYM_W-1:0]    sym;
      logic [COL_W-1:0]    col;
      score_type           up_s;
      len_type             up_l;
      score_type           diag_s;
      len_type             diag_l;
      score_type           init_s;
      score_type           fin_s;
      len_type             fin_l;
      score_type           fin_init_s;
   } sgas_link_type;

   function automatic score_type sat_add(score_type a, logic signed [GAP_W-1:0] b);
      logic signed [SCORE_W:0] sum;
      sum = {a[SCORE_W-1], a} + {{(SCORE_W+1-GAP_W){b[GAP_W-1]}}, b};
      if (sum[SCORE_W] != sum[SCORE_W-1]) begin
         return sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
      end
      return sum[SCORE_W-1:0];
   endfunction

   function automatic len_type inc_len(len_type a);
      if (a == LEN_MAX) begin
         return LEN_MAX;
      end
      return a + len_type'(1);
   endfunction

endpackage

`default_nettype wire

// File: src/sgas_cell.sv
`default_nettype none

module sgas_cell
   import sgas_pkg::*;
#(
   parameter int ROW       = 1,
   parameter int MAX_QUERY = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire gap_type              gap,
   input  wire sub_table_type        sub,
   input  wire logic                 in_vld,
   input  wire sgas_link_type        in_link,
   input  wire logic [((MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1)-1:0] in_widx,
   input  wire logic [$clog2(MAX_QUERY + 1)-1:0] in_qlen,
   output logic                      out_vld,
   output sgas_link_type             out_link,
   output logic [((MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1)-1:0] out_widx,
   output logic [$clog2(MAX_QUERY + 1)-1:0] out_qlen
);

   localparam int QIW = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
   localparam int QLW = $clog2(MAX_QUERY + 1);

   logic                out_vld_ff;
   sgas_link_type       out_link_ff;
   sgas_link_type       out_link_in;
   logic [QIW-1:0]      out_widx_ff;
   logic [QLW-1:0]      out_qlen_ff;
   logic [SYM_W-1:0]    q_ff;
   score_type           s_ff;
   len_type             l_ff;

   score_type           init_s;
   score_type           left_s;
   len_type             left_l;
   logic [REG_W-1:0]    sub_word;
   logic signed [SUB_W-1:0] sub_val;
   score_type           d_s;
   score_type           h_s;
   score_type           v_s;
   score_type           new_s;
   len_type             new_l;
   logic                do_load;
   logic                do_score;

   always_comb begin
      init_s   = sat_add(in_link.init_s, gap);
      left_s   = in_link.first ? init_s : s_ff;
      left_l   = in_link.first ? len_type'(ROW) : l_ff;
      sub_word = sub[in_link.sym];
      sub_val  = sub_word[{q_ff, 4'b0000} +: SUB_W];
      d_s      = sat_add(in_link.diag_s, sub_val);
      h_s      = sat_add(left_s, gap);
      v_s      = sat_add(in_link.up_s, gap);
      new_s    = d_s;
      new_l    = inc_len(in_link.diag_l);
      if ($signed(h_s) > $signed(new_s)) begin
         new_s = h_s;
         new_l = inc_len(left_l);
      end
      if ($signed(v_s) > $signed(new_s)) begin
         new_s = v_s;
         new_l = inc_len(in_link.up_l);
      end
      do_load  = in_vld && !in_link.is_ref && in_link.wr && (in_widx == QIW'(ROW - 1));
      do_score = in_vld && in_link.is_ref && in_link.scored;

      out_link_in        = in_link;
      out_link_in.up_s   = new_s;
      out_link_in.up_l   = new_l;
      out_link_in.diag_s = left_s;
      out_link_in.diag_l = left_l;
      out_link_in.init_s = init_s;
      if (in_qlen == QLW'(ROW)) begin
         out_link_in.fin_s      = new_s;
         out_link_in.fin_l      = new_l;
         out_link_in.fin_init_s = init_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_link_ff <= out_link_in;
         out_widx_ff <= in_widx;
         out_qlen_ff <= in_qlen;
         if (do_load) begin
            q_ff <= in_link.sym;
         end
         if (do_score) begin
            s_ff <= new_s;
            l_ff <= new_l;
         end
      end
   end

   assign out_vld  = out_vld_ff;
   assign out_link = out_link_ff;
   assign out_widx = out_widx_ff;
   assign out_qlen = out_qlen_ff;

endmodule

`default_nettype wire

// File: src/sgas_tail.sv
`default_nettype none

module sgas_tail
   import sgas_pkg::*;
#(
   parameter int MAX_QUERY = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic                 in_vld,
   input  wire sgas_link_type        in_link,
   input  wire logic [$clog2(MAX_QUERY + 1)-1:0] in_qlen,
   input  wire logic                 rsp_tready,
   output logic                      rsp_tvalid,
   output logic [55:0]               rsp_tdata,
   output logic                      rsp_tuser
);

   localparam int QLW = $clog2(MAX_QUERY + 1);

   score_type           best_s_ff;
   len_type             best_l_ff;
   logic [COL_W-1:0]    best_c_ff;
   score_type           best_s_in;
   len_type             best_l_in;
   logic [COL_W-1:0]    best_c_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [55:0]         rsp_data_ff;
   logic                rsp_over_ff;
   logic                take;
   logic                emit;

   always_comb begin
      take = advance && in_vld && in_link.is_ref;
      emit = take && in_link.last;
      if (in_link.first) begin
         best_s_in = in_link.fin_init_s;
         best_l_in = len_type'(in_qlen);
         best_c_in = COL_W'(1);
      end else begin
         best_s_in = best_s_ff;
         best_l_in = best_l_ff;
         best_c_in = best_c_ff;
      end
      if (in_link.scored && ($signed(in_link.fin_s) > $signed(best_s_in))) begin
         best_s_in = in_link.fin_s;
         best_l_in = in_link.fin_l;
         best_c_in = in_link.col;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_s_ff <= best_s_in;
         best_l_ff <= best_l_in;
         best_c_ff <= best_c_in;
      end
      if (emit) begin
         rsp_data_ff <= {best_c_in, best_l_in, best_s_in};
         rsp_over_ff <= in_link.over;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_over_ff;

endmodule

`default_nettype wire

// File: src/semiglobal_alignment_scorer.sv
// the tail registers a result after the last reference request crosses the input register and cells
// throughput: one request per cycle; each reference symbol moves one query cell per cycle down
// the row; both halt only while a finished result waits and the next one reaches the tail
// reset clears control state and sets gap_penalty to -1 and the substitution registers to 0
// the query symbols are undefined until loaded; no clearing pass after reset
`default_nettype none

module semiglobal_alignment_scorer
   import sgas_pkg::*;
#(
   parameter int MAX_QUERY = 64,
   parameter int MAX_REF   = 65535
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // symbol
   input  wire logic                   req_tuser,   // operation
   input  wire logic                   req_tlast,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [55:0]                 rsp_tdata,   // best_score, align_length, end_column
   output logic                        rsp_tuser,   // overflow
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [REG_W-1:0]       csr_data
);

   localparam int QIW = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
   localparam int QLW = $clog2(MAX_QUERY + 1);
   localparam int CW  = $clog2(MAX_REF + 1);
   localparam int XW  = CW + LEN_W;

   gap_type             gap_ff;
   sub_table_type       sub_ff;

   logic [QLW-1:0]      qlen_ff;
   logic [QLW-1:0]      qlen_in;
   logic                qdone_ff;
   logic                qdone_in;
   logic                ref_act_ff;
   logic                ref_act_in;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic                over_ff;
   logic                over_in;

   logic                vld [0:MAX_QUERY];
   sgas_link_type       link [0:MAX_QUERY];
   logic [QIW-1:0]      widx [0:MAX_QUERY];
   logic [QLW-1:0]      qlen [0:MAX_QUERY];

   logic                vld0_ff;
   sgas_link_type       link0_ff;
   sgas_link_type       link0_in;
   logic [QIW-1:0]      widx0_ff;
   logic [QIW-1:0]      widx0_in;
   logic [QLW-1:0]      qlen0_ff;

   logic                advance;
   logic                accept;
   logic [QLW-1:0]      qlen_eff;
   logic [CW-1:0]       count_eff;
   logic [CW-1:0]       col_j;
   logic [XW-1:0]       j_ext;
   logic [XW-1:0]       c_ext;

   assign advance    = !(vld[MAX_QUERY] && link[MAX_QUERY].is_ref && link[MAX_QUERY].last &&
                         rsp_tvalid && !rsp_tready);
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= '1;
         sub_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_GAP:   gap_ff    <= csr_data[GAP_W-1:0];
            REG_SUB_A: sub_ff[0] <= csr_data;
            REG_SUB_C: sub_ff[1] <= csr_data;
            REG_SUB_G: sub_ff[2] <= csr_data;
            REG_SUB_T: sub_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      qlen_in    = qlen_ff;
      qdone_in   = qdone_ff;
      ref_act_in = ref_act_ff;
      count_in   = count_ff;
      over_in    = over_ff;
      qlen_eff   = qdone_ff ? '0 : qlen_ff;
      count_eff  = ref_act_ff ? count_ff : '0;
      col_j      = count_eff + CW'(1);
      j_ext      = XW'(col_j);
      c_ext      = XW'(count_eff);
      widx0_in   = qlen_eff[QIW-1:0];

      link0_in            = '0;
      link0_in.is_ref     = req_tuser;
      link0_in.first      = !ref_act_ff;
      link0_in.last       = req_tlast;
      link0_in.sym        = req_tdata[SYM_W-1:0];
      link0_in.wr         = qlen_eff < QLW'(MAX_QUERY);
      link0_in.col        = j_ext[COL_W-1:0];
      link0_in.up_l       = (j_ext > XW'(LEN_MAX)) ? LEN_MAX : j_ext[LEN_W-1:0];
      link0_in.diag_l     = (c_ext > XW'(LEN_MAX)) ? LEN_MAX : c_ext[LEN_W-1:0];
      link0_in.fin_l      = link0_in.up_l;

      if (!req_tuser) begin
         qdone_in   = req_tlast;
         qlen_in    = link0_in.wr ? qlen_eff + QLW'(1) : qlen_eff;
         ref_act_in = 1'b0;
         count_in   = '0;
      end else begin
         over_in         = ref_act_ff ? over_ff : 1'b0;
         link0_in.scored = count_eff < CW'(MAX_REF);
         if (!link0_in.scored) begin
            over_in = 1'b1;
         end
         link0_in.over = over_in;
         if (req_tlast) begin
            ref_act_in = 1'b0;
            count_in   = '0;
         end else begin
            ref_act_in = 1'b1;
            count_in   = link0_in.scored ? col_j : count_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qlen_ff    <= '0;
         qdone_ff   <= 1'b0;
         ref_act_ff <= 1'b0;
         count_ff   <= '0;
         over_ff    <= 1'b0;
         vld0_ff    <= 1'b0;
      end else if (advance) begin
         vld0_ff <= accept;
         if (accept) begin
            qlen_ff    <= qlen_in;
            qdone_ff   <= qdone_in;
            ref_act_ff <= ref_act_in;
            count_ff   <= count_in;
            over_ff    <= over_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         link0_ff <= link0_in;
         widx0_ff <= widx0_in;
         qlen0_ff <= qlen_ff;
      end
   end

   assign vld[0]  = vld0_ff;
   assign link[0] = link0_ff;
   assign widx[0] = widx0_ff;
   assign qlen[0] = qlen0_ff;

   for (genvar k = 1; k <= MAX_QUERY; k++) begin : g_row
      sgas_cell #(
         .ROW       (k),
         .MAX_QUERY (MAX_QUERY)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .gap      (gap_ff),
         .sub      (sub_ff),
         .in_vld   (vld[k-1]),
         .in_link  (link[k-1]),
         .in_widx  (widx[k-1]),
         .in_qlen  (qlen[k-1]),
         .out_vld  (vld[k]),
         .out_link (link[k]),
         .out_widx (widx[k]),
         .out_qlen (qlen[k])
      );
   end

   sgas_tail #(
      .MAX_QUERY (MAX_QUERY)
   ) u_tail (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_vld     (vld[MAX_QUERY]),
      .in_link    (link[MAX_QUERY]),
      .in_qlen    (qlen[MAX_QUERY]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// File: bench/semiglobal_alignment_scorer_test.sv
module semiglobal_alignment_scorer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sgas_pkg::*;

   localparam int MAX_QUERY = 64;
   localparam int MAX_REF = 65535;
   localparam int LONG_HOLD = 600;
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_REF = 1'b1;

   typedef struct packed {
      logic             op;
      logic [SYM_W-1:0] sym;
      logic             lst;
   } symbol_request_type;

   typedef struct {
      score_type        score;
      len_type          length;
      logic [COL_W-1:0] column;
      logic             ovf;
   } alignment_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [REG_W-1:0] csr_data = '0;

   symbol_request_type pending_requests[$];
   alignment_result_type expected_results[$];
   int mismatches = 0;
   int queued_total = 0;
   int idle_pct = 30;
   int hold_asks = 0;
   logic req_taken = 1'b0;

   // predictor state
   gap_type gap_reg = -1;
   logic [REG_W-1:0] sub_reg[NUM_SYM] = '{default: '0};
   logic [SYM_W-1:0] q_sym[MAX_QUERY];
   int q_len = 0;
   bit q_done = 1'b0;
   int scol[MAX_QUERY+1];
   int unsigned lcol[MAX_QUERY+1];
   int unsigned n_cols = 0;
   bit ref_on = 1'b0;
   bit ref_ovf = 1'b0;
   int best_s = 0;
   int unsigned best_l = 0;
   int unsigned best_c = 1;

   semiglobal_alignment_scorer #(
      .MAX_QUERY(MAX_QUERY),
      .MAX_REF  (MAX_REF)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int clip_score(longint v);
      if (v > 64'sd4194303) return 4194303;
      if (v < -64'sd4194304) return -4194304;
      return int'(v);
   endfunction

   function automatic int unsigned clip_len(longint unsigned v);
      return (v > LEN_MAX) ? LEN_MAX : int'(v);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // advances the alignment state by one accepted request
   task automatic score_request(input logic op, input logic [SYM_W-1:0] sym, input logic lst);
      int g, diag_s, left_s, d, h, v, sv, i;
      int unsigned diag_l, left_l, l;
      alignment_result_type res;
      g = gap_reg;
      if (op == OP_LOAD) begin
         if (q_done) begin
            q_len = 0;
            q_done = 1'b0;
         end
         if (q_len < MAX_QUERY) begin
            q_sym[q_len] = sym;
            q_len++;
         end
         if (lst) q_done = 1'b1;
         ref_on = 1'b0;
         n_cols = 0;
      end else begin
         if (!ref_on) begin
            for (i = 0; i <= q_len; i++) begin
               scol[i] = clip_score(longint'(i) * g);
               lcol[i] = clip_len(i);
            end
            best_s = scol[q_len];
            best_l = lcol[q_len];
            best_c = 1;
            n_cols = 0;
            ref_ovf = 1'b0;
            ref_on = 1'b1;
         end
         if (n_cols >= MAX_REF) begin
            ref_ovf = 1'b1;
         end else begin
            n_cols++;
            diag_s = scol[0];
            diag_l = lcol[0];
            scol[0] = 0;
            lcol[0] = clip_len(n_cols);
            for (i = 1; i <= q_len; i++) begin
               left_s = scol[i];
               left_l = lcol[i];
               sv = $signed(sub_reg[sym][SUB_W*q_sym[i-1] +: SUB_W]);
               d = clip_score(longint'(diag_s) + sv);
               l = clip_len(longint'(diag_l) + 1);
               h = clip_score(longint'(left_s) + g);
               v = clip_score(longint'(scol[i-1]) + g);
               if (h > d) begin
                  d = h;
                  l = clip_len(longint'(left_l) + 1);
               end
               if (v > d) begin
                  d = v;
                  l = clip_len(longint'(lcol[i-1]) + 1);
               end
               diag_s = left_s;
               diag_l = left_l;
               scol[i] = d;
               lcol[i] = l;
            end
            if (scol[q_len] > best_s) begin
               best_s = scol[q_len];
               best_l = lcol[q_len];
               best_c = n_cols;
            end
         end
         if (lst) begin
            res.score = score_type'(best_s);
            res.length = len_type'(best_l);
            res.column = best_c[COL_W-1:0];
            res.ovf = ref_ovf;
            expected_results.push_back(res);
            ref_on = 1'b0;
            n_cols = 0;
         end
      end
   endtask

   // request driver
   always @(negedge clock) begin : driver
      symbol_request_type item;
      int gap_left;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= 1'b0;
         req_tlast <= 1'b0;
         gap_left = 0;
      end else if (req_tvalid && !req_taken) begin
      end else if (gap_left > 0) begin
         req_tvalid <= 1'b0;
         gap_left--;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         gap_left = $urandom_range(4);
      end else if (pending_requests.size() != 0) begin
         item = pending_requests.pop_front();
         req_tvalid <= 1'b1;
         req_tdata <= {6'b0, item.sym};
         req_tuser <= item.op;
         req_tlast <= item.lst;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // result receiver, random stalls plus an occasional long hold
   always @(negedge clock) begin : receiver
      int hold_left, stall_left, holds_seen;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         stall_left = 0;
         holds_seen = 0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (holds_seen != hold_asks) begin
         holds_seen = hold_asks;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(4);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      alignment_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result, score %0d column %0d",
                  $signed(rsp_tdata[SCORE_W-1:0]), rsp_tdata[55:40]));
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[SCORE_W-1:0] !== want.score)
                  report_mismatch($sformatf("best_score %0d, expected %0d",
                     $signed(rsp_tdata[SCORE_W-1:0]), want.score));
               if (rsp_tdata[39:23] !== want.length)
                  report_mismatch($sformatf("align_length %0d, expected %0d",
                     rsp_tdata[39:23], want.length));
               if (rsp_tdata[55:40] !== want.column)
                  report_mismatch($sformatf("end_column %0d, expected %0d",
                     rsp_tdata[55:40], want.column));
               if (rsp_tuser !== want.ovf)
                  report_mismatch($sformatf("overflow %b, expected %b", rsp_tuser, want.ovf));
            end
         end
         if (req_tvalid && req_tready)
            score_request(req_tuser, req_tdata[SYM_W-1:0], req_tlast);
      end
   end

   task automatic queue_request(input logic op, input logic [SYM_W-1:0] sym, input logic lst);
      pending_requests.push_back('{op: op, sym: sym, lst: lst});
      queued_total++;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         REG_GAP: gap_reg = data[GAP_W-1:0];
         REG_SUB_A, REG_SUB_C, REG_SUB_G, REG_SUB_T: sub_reg[idx - REG_SUB_A] = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (MAX_QUERY + 16) @(posedge clock);
   endtask

   // mostly well-formed query loads and references, with some noise and broken sequences
   task automatic queue_traffic(input int budget, input int max_qlen, input int max_rlen);
      int start, kind, n, k;
      start = queued_total;
      while (queued_total - start < budget) begin
         kind = $urandom_range(9);
         if (kind == 0) begin
            queue_request(1'($urandom_range(1)), SYM_W'($urandom_range(3)),
               1'($urandom_range(1)));
         end else if (kind <= 5) begin
            n = ($urandom_range(15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, max_qlen);
            for (k = 0; k < n; k++)
               queue_request(OP_LOAD, SYM_W'($urandom_range(3)), (k == n - 1) && (kind != 1));
         end else begin
            n = $urandom_range(1, max_rlen);
            for (k = 0; k < n; k++)
               queue_request(OP_REF, SYM_W'($urandom_range(3)), (k == n - 1) && (kind != 9));
         end
      end
      queue_request(OP_REF, SYM_W'($urandom_range(3)), 1'b1);
   endtask

   task automatic write_random_config();
      write_register(REG_GAP, {$urandom, $urandom});
      write_register(REG_SUB_A, {$urandom, $urandom});
      write_register(REG_SUB_C, {$urandom, $urandom});
      write_register(REG_SUB_G, {$urandom, $urandom});
      write_register(REG_SUB_T, {$urandom, $urandom});
   endtask

   initial begin
      int k, n;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reference against the empty query, with reset register values
      queue_request(OP_REF, 2'd1, 1'b1);
      wait_idle();

      write_register(REG_GAP, {$urandom, 16'h0, 16'hFFFE});
      write_register(REG_SUB_A, 64'hFFFD_FFFD_FFFD_0005);
      write_register(REG_SUB_C, 64'hFFFD_FFFD_0005_FFFD);
      write_register(REG_SUB_G, 64'hFFFD_0005_FFFD_FFFD);
      write_register(REG_SUB_T, 64'h0005_FFFD_FFFD_FFFD);
      for (k = 0; k < 3; k++)
         write_register(CSR_IDX_W'(REG_SUB_T + 1 + k), {$urandom, $urandom});

      // directed
      for (k = 0; k < 4; k++) queue_request(OP_LOAD, SYM_W'(k), k == 3);
      for (k = 0; k < 4; k++) queue_request(OP_REF, SYM_W'(k), k == 3);
      queue_request(OP_REF, 2'd3, 1'b1);
      // load in the middle of a reference
      queue_request(OP_REF, 2'd0, 1'b0);
      queue_request(OP_LOAD, 2'd2, 1'b1);
      queue_request(OP_REF, 2'd3, 1'b1);
      // reference before the query is complete
      queue_request(OP_LOAD, 2'd0, 1'b0);
      queue_request(OP_LOAD, 2'd1, 1'b0);
      queue_request(OP_REF, 2'd2, 1'b0);
      queue_request(OP_REF, 2'd3, 1'b1);
      queue_request(OP_LOAD, 2'd3, 1'b1);
      queue_request(OP_REF, 2'd0, 1'b1);
      wait_idle();

      write_random_config();
      queue_traffic(50, 12, 16);
      wait_idle();

      // positive extremes drive scores into saturation
      idle_pct = 20;
      write_register(REG_GAP, {$urandom, 16'h0, 16'h7FFF});
      for (k = 0; k < NUM_SYM; k++)
         write_register(CSR_IDX_W'(REG_SUB_A + k), 64'h7FFF_7FFF_7FFF_7FFF);
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++) queue_request(OP_LOAD, SYM_W'($urandom_range(3)), k == n - 1);
      for (k = 0; k < 140; k++) queue_request(OP_REF, SYM_W'($urandom_range(3)), k == 139);
      queue_traffic(20, 16, 20);
      wait_idle();

      // negative extremes
      idle_pct = 0;
      write_register(REG_GAP, {$urandom, 16'h0, 16'h8000});
      for (k = 0; k < NUM_SYM; k++)
         write_register(CSR_IDX_W'(REG_SUB_A + k), 64'h8000_8000_8000_8000);
      queue_traffic(40, 64, 10);
      wait_idle();

      idle_pct = 40;
      write_register(REG_GAP, 64'h0);
      write_register(REG_SUB_A, {64{1'b1}});
      write_register(REG_SUB_C, {$urandom, $urandom});
      write_register(REG_SUB_G, 64'h0);
      write_register(REG_SUB_T, {$urandom, $urandom});
      queue_traffic(40, 20, 8);
      wait_idle();

      // results pile up behind a long receiver hold
      idle_pct = 30;
      write_random_config();
      hold_asks++;
      for (k = 0; k < 3; k++) queue_request(OP_LOAD, SYM_W'($urandom_range(3)), k == 2);
      for (k = 0; k < 80; k++) queue_request(OP_REF, SYM_W'($urandom_range(3)), 1'b1);
      wait_idle();

      // closing traffic, no idling
      idle_pct = 0;
      write_random_config();
      queue_traffic(30, 8, 6);
      wait_idle();

      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
